// ----- src/hedpwm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hedpwm_pkg
// widths, fixed-point constants and register codes of the heading error to
// wheel pwm pipeline
// ----------------------------------------------------------------------------
package hedpwm_pkg;

  // stream payload layout
  localparam int POS_W       = 24;
  localparam int HD_W        = 16;
  localparam int PWM_W       = 16;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 48;

  localparam int RX_LSB = 0;
  localparam int RY_LSB = 24;
  localparam int HD_LSB = 48;
  localparam int TX_LSB = 64;
  localparam int TY_LSB = 88;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int AXLE_W     = 10;
  localparam int SPEED_W    = 10;
  localparam int PWMCFG_W   = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXLE_WIDTH    = 2'd0,
    CFG_NOMINAL_SPEED = 2'd1,
    CFG_MIN_PWM       = 2'd2,
    CFG_MAX_PWM       = 2'd3
  } cfg_idx_t;

  localparam logic [AXLE_W-1:0]   AXLE_RST  = 10'd0;
  localparam logic [SPEED_W-1:0]  SPEED_RST = 10'd50;
  localparam logic [PWMCFG_W-1:0] MINP_RST  = 13'd850;
  localparam logic [PWMCFG_W-1:0] MAXP_RST  = 13'd3000;

  // cordic datapath
  localparam int DX_W       = POS_W + 1;
  localparam int PRE_SHIFT  = 30;
  localparam int XW         = DX_W + PRE_SHIFT + 2;
  localparam int ZW         = 28;
  localparam int MAX_STEPS  = 24;

  localparam logic signed [ZW-1:0] PI_Q24 = 28'sd52707179;

  localparam logic signed [ZW-1:0] ATAN_TAB [MAX_STEPS] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
    28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
    28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
    28'sd256,      28'sd128,     28'sd64,      28'sd32,
    28'sd16,       28'sd8,       28'sd4,       28'sd2
  };

  // angle rounding and wrap
  localparam logic signed [ZW-1:0] Z_ROUND = 28'sd1024;
  localparam int Z_SHIFT = 11;
  localparam int BRG_W   = ZW - Z_SHIFT;
  localparam int ERR_W   = BRG_W + 1;
  localparam logic signed [ERR_W-1:0] PI_Q13     = 18'sd25736;
  localparam logic signed [ERR_W-1:0] TWO_PI_Q13 = 18'sd51472;

  // wheel speed
  localparam int E5_W   = 18;
  localparam int VD_W   = 28;
  localparam int BASE_W = SPEED_W + 15;
  localparam int V_W    = 29;

  // speed to pwm map: (v * 190476 + min * 625 * 2^19) / (625 * 2^19)
  localparam int PROD_W    = 47;
  localparam int NUM_W     = 47;
  localparam int MT_W      = 23;
  localparam int DEN_SHIFT = 19;
  localparam logic [17:0] MAP_NUM    = 18'd190476;
  localparam logic [9:0]  MAP_DEN_LO = 10'd625;

  // floor(m / 625) by reciprocal, off by at most one low
  localparam int M_W     = NUM_W - 1 - DEN_SHIFT;
  localparam int K_W     = 31;
  localparam int RP_W    = M_W + K_W;
  localparam int RECIP_S = 40;
  localparam int Q_W     = RP_W - RECIP_S;
  localparam int R_W     = Q_W + 10;
  localparam logic [K_W-1:0] RECIP_K = 31'd1759218604;

  localparam int P_W = 18;
  localparam logic signed [P_W-1:0] PWM_POS_SAT = 18'sd32767;

endpackage

// ----- src/heading_error_differential_drive_pwm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_error_differential_drive_pwm
// pipelined pure pursuit steering: cordic bearing to the lookahead point,
// wrapped heading error, differential wheel speeds and wheel pwm commands
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  in_     | in  | in_tvalid/in_tready  | pose and lookahead point, 112 bits
//  out_    | out | out_tvalid/out_tready| left/right pwm and heading error
//  cfg_    | in  | cfg_we               | register index and write data
//
//  one item per clock while the output is not stalled; the pipeline holds one cordic
//  micro-rotation per register stage plus the map and divide stages
//  every stage keeps a valid bit; a stage takes a new item whenever out_tready is
//  high or it or a later stage is empty, so bubbles collapse under an output stall
//  rst_n (synchronous) clears valid bits and loads register defaults
//  no storage to clear, the block accepts items right after reset
//
module heading_error_differential_drive_pwm #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // robot_x, robot_y, robot_heading, target_x, target_y
  input  logic [hedpwm_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // left_pwm, right_pwm, heading_error
  output logic [hedpwm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic cfg_we,
  input  logic [hedpwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hedpwm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hedpwm_pkg::*;

  // stage numbering
  localparam int ST_DIFF   = 0;
  localparam int ST_PRE    = 1;
  localparam int ST_CORDIC = 2;
  localparam int ST_E1     = CORDIC_STEPS + 2;   // round bearing, subtract heading
  localparam int ST_E2     = ST_E1 + 1;          // wrap once
  localparam int ST_E3     = ST_E1 + 2;          // 5 * error, base speed
  localparam int ST_E4     = ST_E1 + 3;          // times axle width
  localparam int ST_E5     = ST_E1 + 4;          // left and right speeds
  localparam int ST_E6     = ST_E1 + 5;          // speed times map numerator
  localparam int ST_E7     = ST_E1 + 6;          // add pwm offset
  localparam int ST_E8     = ST_E1 + 7;          // magnitude, drop 2^19
  localparam int ST_E9     = ST_E1 + 8;          // reciprocal multiply
  localparam int ST_E10    = ST_E1 + 9;          // quotient correction
  localparam int ST_E11    = ST_E1 + 10;         // saturate, flip, clamp
  localparam int NS        = ST_E11 + 1;
  localparam int HE_N      = ST_E11 - ST_E2 + 1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [AXLE_W-1:0]   axle_width_r;
  logic [SPEED_W-1:0]  nominal_speed_r;
  logic [PWMCFG_W-1:0] min_pwm_r;
  logic [PWMCFG_W-1:0] max_pwm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axle_width_r    <= AXLE_RST;
      nominal_speed_r <= SPEED_RST;
      min_pwm_r       <= MINP_RST;
      max_pwm_r       <= MAXP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_AXLE_WIDTH:    axle_width_r    <= cfg_wdata[AXLE_W-1:0];
        CFG_NOMINAL_SPEED: nominal_speed_r <= cfg_wdata[SPEED_W-1:0];
        CFG_MIN_PWM:       min_pwm_r       <= cfg_wdata[PWMCFG_W-1:0];
        CFG_MAX_PWM:       max_pwm_r       <= cfg_wdata[PWMCFG_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // flow control: a stage loads when out_tready is high or it, or any stage after it, is empty
  // --------------------------------------------------------------------------
  logic [NS-1:0] vld_r;
  logic [NS-1:0] rdy;

  for (genvar i = 0; i < NS; i++) begin : g_rdy
    assign rdy[i] = out_tready || !(&vld_r[NS-1:i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[ST_DIFF]) vld_r[ST_DIFF] <= in_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign in_tready  = rdy[ST_DIFF];
  assign out_tvalid = vld_r[NS-1];

  // --------------------------------------------------------------------------
  // stage 0: position differences
  // --------------------------------------------------------------------------
  logic signed [POS_W-1:0] rx, ry, tx, ty;
  logic signed [DX_W-1:0]  dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [HD_W-1:0]  hd_r;

  always_comb begin
    rx     = $signed(in_tdata[RX_LSB +: POS_W]);
    ry     = $signed(in_tdata[RY_LSB +: POS_W]);
    tx     = $signed(in_tdata[TX_LSB +: POS_W]);
    ty     = $signed(in_tdata[TY_LSB +: POS_W]);
    dx_nxt = DX_W'(tx) - DX_W'(rx);
    dy_nxt = DX_W'(ty) - DX_W'(ry);
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_DIFF]) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      hd_r <= $signed(in_tdata[HD_LSB +: HD_W]);
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: scale by 2^30, fold the left half plane onto the right
  // stages 2 .. CORDIC_STEPS+1: one vectoring micro-rotation each
  // --------------------------------------------------------------------------
  logic signed [XW-1:0]   cx_r [CORDIC_STEPS+1];
  logic signed [XW-1:0]   cy_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0]   cz_r [CORDIC_STEPS+1];
  logic signed [HD_W-1:0] chd_r [CORDIC_STEPS+1];
  logic                   czero_r [CORDIC_STEPS+1];

  logic signed [XW-1:0]   x_ext, y_ext, x0_nxt, y0_nxt;
  logic signed [ZW-1:0]   z0_nxt;
  logic signed [XW-1:0]   cx_nxt [CORDIC_STEPS];
  logic signed [XW-1:0]   cy_nxt [CORDIC_STEPS];
  logic signed [ZW-1:0]   cz_nxt [CORDIC_STEPS];

  always_comb begin
    x_ext = XW'(dx_r) <<< PRE_SHIFT;
    y_ext = XW'(dy_r) <<< PRE_SHIFT;
    if (dx_r[DX_W-1]) begin
      x0_nxt = -x_ext;
      y0_nxt = -y_ext;
      z0_nxt = dy_r[DX_W-1] ? -PI_Q24 : PI_Q24;
    end else begin
      x0_nxt = x_ext;
      y0_nxt = y_ext;
      z0_nxt = '0;
    end
  end

  always_comb begin
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      if (!cy_r[k][XW-1]) begin
        cx_nxt[k] = cx_r[k] + (cy_r[k] >>> k);
        cy_nxt[k] = cy_r[k] - (cx_r[k] >>> k);
        cz_nxt[k] = cz_r[k] + ATAN_TAB[k];
      end else begin
        cx_nxt[k] = cx_r[k] - (cy_r[k] >>> k);
        cy_nxt[k] = cy_r[k] + (cx_r[k] >>> k);
        cz_nxt[k] = cz_r[k] - ATAN_TAB[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_PRE]) begin
      cx_r[0]    <= x0_nxt;
      cy_r[0]    <= y0_nxt;
      cz_r[0]    <= z0_nxt;
      chd_r[0]   <= hd_r;
      czero_r[0] <= (dx_r == '0) && (dy_r == '0);
    end
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      if (rdy[ST_CORDIC+k]) begin
        cx_r[k+1]    <= cx_nxt[k];
        cy_r[k+1]    <= cy_nxt[k];
        cz_r[k+1]    <= cz_nxt[k];
        chd_r[k+1]   <= chd_r[k];
        czero_r[k+1] <= czero_r[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // E1: round bearing to q2.13 and subtract heading
  // E2: wrap once into [-pi, pi]
  // --------------------------------------------------------------------------
  logic signed [ZW-1:0]    zsum;
  logic signed [BRG_W-1:0] brg;
  logic signed [ERR_W-1:0] eraw_r, eraw_nxt, ewrap;
  logic signed [HD_W-1:0]  herr_r [HE_N];

  always_comb begin
    zsum     = cz_r[CORDIC_STEPS] + Z_ROUND;
    brg      = czero_r[CORDIC_STEPS] ? '0 : $signed(zsum[ZW-1:Z_SHIFT]);
    eraw_nxt = ERR_W'(brg) - ERR_W'(chd_r[CORDIC_STEPS]);
  end

  always_comb begin
    priority if (eraw_r < -PI_Q13) begin
      ewrap = eraw_r + TWO_PI_Q13;
    end else if (eraw_r > PI_Q13) begin
      ewrap = eraw_r - TWO_PI_Q13;
    end else begin
      ewrap = eraw_r;
    end
  end

  // heading error rides along to the output
  always_ff @(posedge clk) begin
    if (rdy[ST_E1]) eraw_r <= eraw_nxt;
    if (rdy[ST_E2]) herr_r[0] <= ewrap[HD_W-1:0];
    for (int j = 1; j < HE_N; j++) begin
      if (rdy[ST_E2+j]) herr_r[j] <= herr_r[j-1];
    end
  end

  // --------------------------------------------------------------------------
  // E3..E5: speed difference 5 * err * axle (units of 2^-15 mm/s) and the
  // two wheel speeds; lane 0 is left (minus), lane 1 is right (plus)
  // --------------------------------------------------------------------------
  logic signed [E5_W-1:0]  err5_r;
  logic [BASE_W-1:0]       base3_r, base4_r;
  logic signed [VD_W-1:0]  vdiff_r;
  logic signed [V_W-1:0]   v_r [2];

  always_ff @(posedge clk) begin
    if (rdy[ST_E3]) begin
      err5_r  <= (E5_W'(herr_r[0]) <<< 2) + E5_W'(herr_r[0]);
      base3_r <= {nominal_speed_r, 15'd0};
    end
    if (rdy[ST_E4]) begin
      vdiff_r <= VD_W'(err5_r) * VD_W'($signed({1'b0, axle_width_r}));
      base4_r <= base3_r;
    end
    if (rdy[ST_E5]) begin
      v_r[0] <= V_W'($signed({1'b0, base4_r})) - V_W'(vdiff_r);
      v_r[1] <= V_W'($signed({1'b0, base4_r})) + V_W'(vdiff_r);
    end
  end

  // --------------------------------------------------------------------------
  // E6..E10: q = trunc((v * 190476 + min * 625 * 2^19) / (625 * 2^19))
  // magnitude first, the 2^19 part is a shift, the 625 part a reciprocal
  // multiply with one correction step
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_r [2];
  logic [MT_W-1:0]          mt_r;
  logic signed [NUM_W-1:0]  num_r [2];
  logic [NUM_W-1:0]         mag [2];
  logic [M_W-1:0]           m8_r [2], m9_r [2];
  logic [RP_W-1:0]          rprod [2];
  logic [Q_W-1:0]           q0_r [2], q_r [2];
  logic [R_W-1:0]           rem [2];
  logic                     vneg6_r [2], vneg7_r [2], vneg8_r [2], vneg9_r [2], vneg10_r [2];
  logic                     nneg8_r [2], nneg9_r [2], nneg10_r [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag[l]   = num_r[l][NUM_W-1] ? NUM_W'(-num_r[l]) : NUM_W'(num_r[l]);
      rprod[l] = RP_W'(m8_r[l]) * RP_W'(RECIP_K);
      rem[l]   = R_W'(m9_r[l]) - R_W'(q0_r[l]) * R_W'(MAP_DEN_LO);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_E6]) mt_r <= MT_W'(min_pwm_r) * MT_W'(MAP_DEN_LO);
    for (int l = 0; l < 2; l++) begin
      if (rdy[ST_E6]) begin
        prod_r[l]  <= PROD_W'(v_r[l]) * $signed(PROD_W'(MAP_NUM));
        vneg6_r[l] <= v_r[l][V_W-1];
      end
      if (rdy[ST_E7]) begin
        num_r[l]   <= prod_r[l] + $signed(NUM_W'({mt_r, DEN_SHIFT'(0)}));
        vneg7_r[l] <= vneg6_r[l];
      end
      if (rdy[ST_E8]) begin
        m8_r[l]    <= mag[l][NUM_W-2:DEN_SHIFT];
        nneg8_r[l] <= num_r[l][NUM_W-1];
        vneg8_r[l] <= vneg7_r[l];
      end
      if (rdy[ST_E9]) begin
        q0_r[l]    <= rprod[l][RP_W-1:RECIP_S];
        m9_r[l]    <= m8_r[l];
        nneg9_r[l] <= nneg8_r[l];
        vneg9_r[l] <= vneg8_r[l];
      end
      if (rdy[ST_E10]) begin
        q_r[l]      <= (rem[l] >= R_W'(MAP_DEN_LO)) ? q0_r[l] + Q_W'(1) : q0_r[l];
        nneg10_r[l] <= nneg9_r[l];
        vneg10_r[l] <= vneg9_r[l];
      end
    end
  end

  // --------------------------------------------------------------------------
  // E11: saturate to int16, negate for reverse speed, clamp above at max_pwm
  // --------------------------------------------------------------------------
  logic signed [P_W-1:0]   psat [2], pflip [2], pfin [2];
  logic [Q_W-1:0]          qlim [2];
  logic signed [PWM_W-1:0] pwm_r [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (!nneg10_r[l]) begin
        qlim[l] = (q_r[l] > Q_W'(32767)) ? Q_W'(32767) : q_r[l];
        psat[l] = $signed(P_W'(qlim[l]));
      end else begin
        qlim[l] = (q_r[l] > Q_W'(32768)) ? Q_W'(32768) : q_r[l];
        psat[l] = -$signed(P_W'(qlim[l]));
      end
      pflip[l] = psat[l];
      if (vneg10_r[l]) begin
        pflip[l] = -psat[l];
        if (pflip[l] > PWM_POS_SAT) pflip[l] = PWM_POS_SAT;
      end
      pfin[l] = pflip[l];
      if (pflip[l] > $signed(P_W'(max_pwm_r))) pfin[l] = $signed(P_W'(max_pwm_r));
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (rdy[ST_E11]) pwm_r[l] <= pfin[l][PWM_W-1:0];
    end
  end

  assign out_tdata = {herr_r[HE_N-1], pwm_r[1], pwm_r[0]};

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  logic signed [PWM_W-1:0] chk_left, chk_right, chk_err;
  assign chk_left  = $signed(out_tdata[15:0]);
  assign chk_right = $signed(out_tdata[31:16]);
  assign chk_err   = $signed(out_tdata[47:32]);

  // single wrap always lands inside [-pi, pi]
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (chk_err >= -16'sd25736) && (chk_err <= 16'sd25736))
    else $error("heading error outside [-pi, pi]");

  // upper clamp can never let a command exceed the 13 bit max_pwm range
  a_pwm_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (chk_left <= 16'sd8191) && (chk_right <= 16'sd8191))
    else $error("wheel pwm above clamp range");

  // a bubble anywhere in the pipe must let the input side accept
  a_bubble_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (!(&vld_r) || out_tready) |-> in_tready)
    else $error("input stalled while the pipeline has room");

endmodule

// ----- tb/heading_error_differential_drive_pwm_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_error_differential_drive_pwm_tb
// self-checking bench for the steering pipeline: pose items go in on the
// in_ stream, wheel commands come back on the out_ stream and are compared
// field by field with a bit-exact behavioral copy of the steering math, under
// several register settings, bursty input and a stalling receiver
// ----------------------------------------------------------------------------
module heading_error_differential_drive_pwm_tb;
  import hedpwm_pkg::*;

  localparam int CORDIC_STEPS = 16;
  // pipeline depth given for the block, used for the tail wait
  localparam int PIPE_DEPTH   = CORDIC_STEPS + 13;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 150;

  // fixed-point constants of the steering math
  localparam longint PI_Q24_R  = 64'sd52707179;
  localparam longint PI_Q13_R  = 64'sd25736;
  localparam longint TWO_PI_R  = 64'sd51472;
  localparam longint SPEED_MUL = 64'sd190476;
  localparam longint SPEED_DIV = 64'sd327680000;
  // 50 mm/s * 19.0476 + 850 = 1802.38, both wheels when axle_width is 0
  localparam int RESET_CRUISE_PWM = 1802;

  localparam longint ARCTAN_Q24 [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  // in_tdata layout, lowest bits first: rx, ry, hd, tx, ty
  typedef struct packed {
    logic signed [POS_W-1:0] ty;
    logic signed [POS_W-1:0] tx;
    logic signed [HD_W-1:0]  hd;
    logic signed [POS_W-1:0] ry;
    logic signed [POS_W-1:0] rx;
  } pose_t;

  // out_tdata layout, lowest bits first: left, right, heading error
  typedef struct packed {
    logic signed [PWM_W-1:0] heading_error;
    logic signed [PWM_W-1:0] right_pwm;
    logic signed [PWM_W-1:0] left_pwm;
  } wheel_cmd_t;

  // one row of the directed table; err only meaningful when typed is set
  typedef struct packed {
    logic                    typed;
    logic signed [PWM_W-1:0] err;
    pose_t                   pose;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // robot_x, robot_y, robot_heading, target_x, target_y
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // left_pwm, right_pwm, heading_error
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // register shadow, follows every write seen on the cfg_ port
  logic [AXLE_W-1:0]   cur_axle;
  logic [SPEED_W-1:0]  cur_speed;
  logic [PWMCFG_W-1:0] cur_min_pwm;
  logic [PWMCFG_W-1:0] cur_max_pwm;

  wheel_cmd_t pending_cmds[$];
  stim_row_t  plan[$];
  int error_count = 0;
  int cycle_count = 0;
  int items_sent  = 0;
  int burst_left  = 0;

  heading_error_differential_drive_pwm #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // steering math
  // ------------------------------------------------------------------------

  // vectoring cordic, angle kept in 2^-24 rad, returned rounded to q2.13
  function automatic longint bearing_q13(longint dx, longint dy);
    longint x, y, z, xs, ys;
    int i;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    x = dx <<< 30;
    y = dy <<< 30;
    // left half plane: turn the vector by pi first
    if (x < 0) begin
      z = (y >= 0) ? PI_Q24_R : -PI_Q24_R;
      x = -x;
      y = -y;
    end
    for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_Q24[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_Q24[i];
      end
    end
    return (z + 64'sd1024) >>> 11;
  endfunction

  // wheel speed in 2^-15 mm/s to pwm: exact map, int16 saturation,
  // sign flip for reverse and upper clamp only
  function automatic longint speed_to_pwm(longint v);
    longint num, p;
    num = v * SPEED_MUL + longint'(cur_min_pwm) * SPEED_DIV;
    p = num / SPEED_DIV;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    if (v < 0) begin
      p = -p;
      if (p > 32767) p = 32767;
    end
    if (p > longint'(cur_max_pwm)) p = longint'(cur_max_pwm);
    return p;
  endfunction

  function automatic wheel_cmd_t steer_command(pose_t p);
    longint err, vdiff, base, pl, pr;
    wheel_cmd_t c;
    err = bearing_q13(longint'(p.tx) - longint'(p.rx),
                      longint'(p.ty) - longint'(p.ry)) - longint'(p.hd);
    // single wrap into [-pi, pi]
    if (err < -PI_Q13_R) err = err + TWO_PI_R;
    else if (err > PI_Q13_R) err = err - TWO_PI_R;
    vdiff = 64'sd5 * err * longint'(cur_axle);
    base = longint'(cur_speed) * 64'sd32768;
    pl = speed_to_pwm(base - vdiff);
    pr = speed_to_pwm(base + vdiff);
    c.left_pwm = pl[15:0];
    c.right_pwm = pr[15:0];
    c.heading_error = err[15:0];
    return c;
  endfunction

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  function automatic stim_row_t row(input logic typed, input int err, input int rx,
                                    input int ry, input int hd, input int tx,
                                    input int ty);
    stim_row_t r;
    r.typed = typed;
    r.err = err[15:0];
    r.pose.rx = rx[23:0];
    r.pose.ry = ry[23:0];
    r.pose.hd = hd[15:0];
    r.pose.tx = tx[23:0];
    r.pose.ty = ty[23:0];
    return r;
  endfunction

  // mostly lookahead points near the robot at random scales, plus the
  // degenerate geometries and fully random far points
  function automatic stim_row_t random_row();
    stim_row_t r;
    logic signed [POS_W-1:0] dx, dy;
    int k;
    r.typed = 1'b0;
    r.err = '0;
    r.pose.rx = POS_W'($urandom());
    r.pose.ry = POS_W'($urandom());
    r.pose.hd = HD_W'(int'($urandom_range(0, 51472)) - 25736);
    if ($urandom_range(0, 15) == 0)
      r.pose.hd = $urandom_range(0, 1) ? HD_W'(25736) : HD_W'(-25736);
    r.pose.tx = POS_W'($urandom());
    r.pose.ty = POS_W'($urandom());
    k = $urandom_range(0, 23);
    dx = POS_W'(int'($urandom()) >>> (31 - k));
    dy = POS_W'(int'($urandom()) >>> (31 - $urandom_range(0, 23)));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
      end
      6: begin
        dx = '0;
        dy = '0;
      end
      7: dy = '0;
      8: dx = '0;
      9: dy = $urandom_range(0, 1) ? dx : -dx;
      default: return r;
    endcase
    r.pose.tx = r.pose.rx + dx;
    r.pose.ty = r.pose.ry + dy;
    return r;
  endfunction

  // offer one item; the sender runs in bursts separated by random gaps
  task automatic offer(input stim_row_t r);
    int gap;
    wheel_cmd_t want;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = r.pose;
    do @(posedge clk); while (!in_tready);
    if (r.typed) begin
      want.left_pwm = PWM_W'(RESET_CRUISE_PWM);
      want.right_pwm = PWM_W'(RESET_CRUISE_PWM);
      want.heading_error = r.err;
    end else begin
      want = steer_command(r.pose);
    end
    pending_cmds.push_back(want);
    items_sent++;
  endtask

  // stop offering and wait until every command has come back
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    burst_left = 0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // the 10-bit registers get junk in the unused upper data bits
  task automatic apply_settings(input int axle, input int speed, input int minp,
                                input int maxp);
    logic [2:0] junk;
    junk = 3'($urandom_range(0, 7));
    write_reg(CFG_AXLE_WIDTH, {junk, axle[9:0]});
    junk = 3'($urandom_range(0, 7));
    write_reg(CFG_NOMINAL_SPEED, {junk, speed[9:0]});
    write_reg(CFG_MIN_PWM, minp[12:0]);
    write_reg(CFG_MAX_PWM, maxp[12:0]);
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_AXLE_WIDTH;
    cfg_wdata = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // target on the robot: bearing 0, error is minus the heading
    plan.push_back(row(1, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(1, -25736, -8388608, -8388608, 25736, -8388608, -8388608));
    plan.push_back(row(1, 25736, 8388607, 8388607, -25736, 8388607, 8388607));
    // heading past pi on both sides, one wrap brings the error back
    plan.push_back(row(1, 18705, 1234, -77, 32767, 1234, -77));
    plan.push_back(row(1, -18704, -5, 9, -32768, -5, 9));
    // widest differences on each axis
    plan.push_back(row(0, 0, -8388608, 0, 0, 8388607, 0));
    plan.push_back(row(0, 0, 0, -8388608, 100, 0, 8388607));
    plan.push_back(row(0, 0, 0, 8388607, -100, 0, -8388608));
    plan.push_back(row(0, 0, 8388607, 5, 0, -8388608, 5));
    // tiny offsets straight behind, diagonally behind and ahead, some with headings that force a wrap
    plan.push_back(row(0, 0, 1, 0, 0, 0, 0));
    plan.push_back(row(0, 0, 1, 0, -25736, 0, 0));
    plan.push_back(row(0, 0, 1, 1, 25736, 0, 0));
    plan.push_back(row(0, 0, 0, 0, -25736, 1, -1));

    // first pass at the reset settings, typed rows checked against fixed values
    foreach (plan[i]) offer(plan[i]);
    drain();

    // second pass with a wide axle and no forward speed: reverse wheels,
    // int16 saturation and the negation of the most negative value
    apply_settings(1023, 0, 0, 8191);
    foreach (plan[i]) begin
      plan[i].typed = 1'b0;
      offer(plan[i]);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case (ph)
        0: apply_settings(1023, 1023, 8191, 8191);
        1: apply_settings(1023, 0, 0, 0);
        2: apply_settings(0, 1023, 0, 8191);
        default: apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                                $urandom_range(0, 4000), $urandom_range(0, 8191));
      endcase
      repeat (PHASE_ITEMS) offer(random_row());
    end

    drain();
    // anything extra still in flight would show up here as unexpected
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (error_count == 0 && pending_cmds.size() == 0) begin
      $display("heading_error_differential_drive_pwm test passed");
    end else begin
      $display("heading_error_differential_drive_pwm test failed");
    end
    $finish;
  end

  // ------------------------------------------------------------------------
  // receiver: changing stall patterns, plus two long hold-offs while the
  // sender keeps offering so the pipeline fills and stalls in_tready
  // ------------------------------------------------------------------------
  initial begin
    int hold_left, window_left, mode, next_hold;
    int hold_mark [2];
    hold_mark[0] = 300;
    hold_mark[1] = 700;
    hold_left = 0;
    window_left = 0;
    mode = 0;
    next_hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (next_hold < 2 && items_sent >= hold_mark[next_hold]) begin
        hold_left = 150;
        next_hold++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        if (window_left == 0) begin
          window_left = $urandom_range(16, 96);
          mode = $urandom_range(0, 3);
        end
        window_left--;
        case (mode)
          0: out_tready = 1'b1;
          1: out_tready = ($urandom_range(0, 3) != 0);
          2: out_tready = ($urandom_range(0, 3) == 0);
          default: out_tready = window_left[0];
        endcase
      end
    end
  end

  // ------------------------------------------------------------------------
  // register shadow and result checker, sampled at the rising edge
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    wheel_cmd_t got, want;
    if (!rst_n) begin
      cur_axle = AXLE_RST;
      cur_speed = SPEED_RST;
      cur_min_pwm = MINP_RST;
      cur_max_pwm = MAXP_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AXLE_WIDTH:    cur_axle = cfg_wdata[AXLE_W-1:0];
          CFG_NOMINAL_SPEED: cur_speed = cfg_wdata[SPEED_W-1:0];
          CFG_MIN_PWM:       cur_min_pwm = cfg_wdata[PWMCFG_W-1:0];
          CFG_MAX_PWM:       cur_max_pwm = cfg_wdata[PWMCFG_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_cmds.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected item: left %0d right %0d err %0d",
                     got.left_pwm, got.right_pwm, got.heading_error);
        end else begin
          want = pending_cmds.pop_front();
          if (got.left_pwm !== want.left_pwm || got.right_pwm !== want.right_pwm ||
              got.heading_error !== want.heading_error) begin
            error_count++;
            if (error_count <= 10)
              $display({"mismatch: expected left %0d right %0d err %0d, ",
                        "got left %0d right %0d err %0d"},
                       want.left_pwm, want.right_pwm, want.heading_error,
                       got.left_pwm, got.right_pwm, got.heading_error);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("heading_error_differential_drive_pwm test failed");
      $finish;
    end
  end

endmodule
